// File: sv/slcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int BUF_DEPTH   = MAX_PAYLOAD + 1;
  localparam int BUF_AW      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int IDX_W       = 6;
  localparam int CFG_AW      = 4;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam logic [7:0] RST_START_BYTE    = 8'd2;
  localparam logic [31:0] RST_BYTE_TIMEOUT  = 32'd50;
  localparam logic [31:0] RST_FRAME_TIMEOUT = 32'd200;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MSG     = 2'd0,
    KIND_BADLEN  = 2'd1,
    KIND_CRC     = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_READ = 2'd1,
    CS_OUT  = 2'd2
  } ctl_state_t;

  typedef enum logic [1:0] {
    REG_START_BYTE    = 2'd0,
    REG_BYTE_TIMEOUT  = 2'd1,
    REG_FRAME_TIMEOUT = 2'd2
  } reg_idx_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/slcfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module slcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/stx_len_crc8_frame_receiver_core.sv
// Frame receiver for START, LEN, CMD+payload, CRC-8 (poly 0x07, init 0) byte streams with
// inter-byte and whole-frame timeouts. An item that yields no result leaves in_ready high.
// A result that carries a buffer byte (message bytes, crc errors, timeouts after a data byte)
// passes through CS_READ and then CS_OUT, since the frame buffer RAM has a single registered
// read port: CS_READ waits for the buffer read and CS_OUT presents the result. A bad length
// or a timeout before any data byte needs no read and goes straight to CS_OUT. A delivered
// message of LEN bytes thus keeps in_ready low while each byte passes CS_READ and CS_OUT
// and while the sink stalls; the block handles one item at a time. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stx_len_crc8_frame_receiver_core
  import slcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_rx_byte,
  input  logic [31:0]       in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_out_byte,
  output logic [IDX_W-1:0]  out_byte_index,
  output logic [IDX_W-1:0]  out_payload_count,
  output logic              out_last,
  output logic [31:0]       out_start_time,
  output logic [31:0]       out_end_time,
  output logic [31:0]       out_broken_count,
  output logic [31:0]       out_timeout_count,
  output logic [31:0]       out_crc_fail_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]  start_byte_r;
  logic [31:0] byte_to_r;
  logic [31:0] frame_to_r;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] flen_r, flen_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [31:0]      fst_r, fst_nxt;
  logic [31:0]      lbt_r, lbt_nxt;
  logic [31:0]      broken_r, broken_nxt;
  logic [31:0]      tmo_cnt_r, tmo_cnt_nxt;
  logic [31:0]      crcf_r, crcf_nxt;

  ctl_state_t cs_r, cs_nxt;

  kind_t            kind_r;
  logic [IDX_W-1:0] idx_r, idx_inc;
  logic [IDX_W-1:0] pc_r;
  logic [31:0]      st_r, et_r;
  logic             use_ram_r;

  logic             in_acc, out_acc, cfg_wr;
  logic             tmo;
  logic [31:0]      dt_byte, dt_frame;
  phase_t           eff_phase;
  logic             res_any, res_rd;
  kind_t            res_kind;
  logic [IDX_W-1:0] res_pc;
  logic [31:0]      res_et;
  logic             more;

  logic              ram_we, ram_re;
  logic [BUF_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign pready  = 1'b1;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= RST_START_BYTE;
      byte_to_r    <= RST_BYTE_TIMEOUT;
      frame_to_r   <= RST_FRAME_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_START_BYTE:    start_byte_r <= pwdata[7:0];
        REG_BYTE_TIMEOUT:  byte_to_r    <= pwdata;
        REG_FRAME_TIMEOUT: frame_to_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_START_BYTE:    prdata = {24'd0, start_byte_r};
      REG_BYTE_TIMEOUT:  prdata = byte_to_r;
      REG_FRAME_TIMEOUT: prdata = frame_to_r;
      default:           prdata = 32'd0;
    endcase
  end

  assign dt_byte  = in_now_ms - lbt_r;
  assign dt_frame = in_now_ms - fst_r;
  assign tmo      = (phase_r != PH_IDLE) && ((dt_byte > byte_to_r) || (dt_frame > frame_to_r));

  // parser update for one accepted item
  always_comb begin
    phase_nxt   = phase_r;
    flen_nxt    = flen_r;
    fill_nxt    = fill_r;
    crc_nxt     = crc_r;
    fst_nxt     = fst_r;
    lbt_nxt     = lbt_r;
    broken_nxt  = broken_r;
    tmo_cnt_nxt = tmo_cnt_r;
    crcf_nxt    = crcf_r;
    eff_phase   = phase_r;
    res_any     = 1'b0;
    res_rd      = 1'b0;
    res_kind    = KIND_TIMEOUT;
    res_pc      = '0;
    res_et      = '0;
    ram_we      = 1'b0;
    if (in_acc) begin
      if (tmo) begin
        broken_nxt  = broken_r + 32'd1;
        tmo_cnt_nxt = tmo_cnt_r + 32'd1;
        res_any     = 1'b1;
        res_kind    = KIND_TIMEOUT;
        res_rd      = (fill_r != '0);
        eff_phase   = PH_IDLE;
        phase_nxt   = PH_IDLE;
        flen_nxt    = '0;
        fill_nxt    = '0;
        crc_nxt     = '0;
        fst_nxt     = '0;
        lbt_nxt     = '0;
      end
      if (in_op) begin
        unique case (eff_phase)
          PH_IDLE: begin
            if (in_rx_byte == start_byte_r) begin
              phase_nxt = PH_LEN;
              fst_nxt   = in_now_ms;
              lbt_nxt   = in_now_ms;
              crc_nxt   = '0;
            end
          end
          PH_LEN: begin
            if ((in_rx_byte == 8'd0) || (in_rx_byte > 8'(BUF_DEPTH))) begin
              broken_nxt = broken_r + 32'd1;
              res_any    = 1'b1;
              res_kind   = KIND_BADLEN;
              phase_nxt  = PH_IDLE;
              flen_nxt   = '0;
              fill_nxt   = '0;
              crc_nxt    = '0;
              fst_nxt    = '0;
              lbt_nxt    = '0;
            end else begin
              lbt_nxt   = in_now_ms;
              flen_nxt  = in_rx_byte[IDX_W-1:0];
              crc_nxt   = crc8_step(crc_r, in_rx_byte);
              fill_nxt  = '0;
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            lbt_nxt  = in_now_ms;
            ram_we   = 1'b1;
            fill_nxt = fill_r + IDX_W'(1);
            crc_nxt  = crc8_step(crc_r, in_rx_byte);
            if (fill_nxt >= flen_r) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            res_any = 1'b1;
            res_rd  = 1'b1;
            res_et  = in_now_ms;
            if (in_rx_byte != crc_r) begin
              crcf_nxt = crcf_r + 32'd1;
              res_kind = KIND_CRC;
            end else begin
              res_kind = KIND_MSG;
              res_pc   = flen_r - IDX_W'(1);
            end
            phase_nxt = PH_IDLE;
            flen_nxt  = '0;
            fill_nxt  = '0;
            crc_nxt   = '0;
            fst_nxt   = '0;
            lbt_nxt   = '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign idx_inc = idx_r + IDX_W'(1);
  assign more    = (kind_r == KIND_MSG) && (idx_r != pc_r);

  // control next state
  always_comb begin
    cs_nxt = cs_r;
    unique case (cs_r)
      CS_IDLE: begin
        if (in_acc && res_any) begin
          cs_nxt = res_rd ? CS_READ : CS_OUT;
        end
      end
      CS_READ: cs_nxt = CS_OUT;
      CS_OUT: begin
        if (out_ready) begin
          cs_nxt = more ? CS_READ : CS_IDLE;
        end
      end
      default: cs_nxt = CS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (cs_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        ram_re   = in_acc && res_rd;
      end
      CS_READ: ;
      CS_OUT: begin
        out_valid = 1'b1;
        ram_re    = out_ready && more;
        ram_raddr = idx_inc[BUF_AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r      <= CS_IDLE;
      phase_r   <= PH_IDLE;
      flen_r    <= '0;
      fill_r    <= '0;
      crc_r     <= '0;
      fst_r     <= '0;
      lbt_r     <= '0;
      broken_r  <= '0;
      tmo_cnt_r <= '0;
      crcf_r    <= '0;
    end else begin
      cs_r      <= cs_nxt;
      phase_r   <= phase_nxt;
      flen_r    <= flen_nxt;
      fill_r    <= fill_nxt;
      crc_r     <= crc_nxt;
      fst_r     <= fst_nxt;
      lbt_r     <= lbt_nxt;
      broken_r  <= broken_nxt;
      tmo_cnt_r <= tmo_cnt_nxt;
      crcf_r    <= crcf_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_acc && res_any) begin
      kind_r    <= res_kind;
      idx_r     <= '0;
      pc_r      <= res_pc;
      st_r      <= fst_r;
      et_r      <= res_et;
      use_ram_r <= res_rd;
    end else if (out_acc && more) begin
      idx_r <= idx_inc;
    end
  end

  slcfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH),
    .AW    (BUF_AW)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[BUF_AW-1:0]),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_kind           = kind_r;
  assign out_out_byte       = use_ram_r ? ram_rdata : 8'd0;
  assign out_byte_index     = idx_r;
  assign out_payload_count  = pc_r;
  assign out_last           = !more;
  assign out_start_time     = st_r;
  assign out_end_time       = et_r;
  assign out_broken_count   = broken_r;
  assign out_timeout_count  = tmo_cnt_r;
  assign out_crc_fail_count = crcf_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_MSG) |-> (out_byte_index <= out_payload_count))
    else $error("message index beyond payload count");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_MSG) |-> (out_last && out_byte_index == '0))
    else $error("error result not alone");

  a_back_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not ready after final result");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (fill_r < flen_r))
    else $error("fill index passed frame length");

endmodule

`default_nettype wire
